/* hw/rtl/mts_pkg.sv */
// Shared types, token codes and character helpers for the micro token scanner.
package mts_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_IDENT    = 3'd1,
        MODE_INT      = 3'd2,
        MODE_FRAC     = 3'd3,
        MODE_EXP_E    = 3'd4,
        MODE_EXP_TAIL = 3'd5,
        MODE_COLON    = 3'd6
    } t_mode;

    typedef enum logic [4:0] {
        TK_BEGIN   = 5'd0,
        TK_READ    = 5'd1,
        TK_WRITE   = 5'd2,
        TK_END     = 5'd3,
        TK_IDENT   = 5'd4,
        TK_INT     = 5'd5,
        TK_REAL    = 5'd6,
        TK_LPAREN  = 5'd7,
        TK_RPAREN  = 5'd8,
        TK_SEMI    = 5'd9,
        TK_COMMA   = 5'd10,
        TK_PLUS    = 5'd11,
        TK_MINUS   = 5'd12,
        TK_ASSIGN  = 5'd13,
        TK_NEWLINE = 5'd14,
        TK_ERROR   = 5'd15,
        TK_EOF     = 5'd16
    } t_tok;

    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_EXP    = 8'h65;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam int KW_COUNT = 4;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Keyword lengths: BEGIN, READ, WRITE, END.
    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        case (k)
            2'd0:    len = 3'd5;
            2'd1:    len = 3'd4;
            2'd2:    len = 3'd5;
            default: len = 3'd3;
        endcase
        return len;
    endfunction

    // Character of keyword k at position pos; only valid below kw_len(k).
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [39:0] text;
        logic [7:0]  ch;
        case (k)
            2'd0:    text = "BEGIN";
            2'd1:    text = {"READ", 8'h00};
            2'd2:    text = "WRITE";
            default: text = {"END", 16'h0000};
        endcase
        case (pos)
            3'd0:    ch = text[39:32];
            3'd1:    ch = text[31:24];
            3'd2:    ch = text[23:16];
            3'd3:    ch = text[15:8];
            3'd4:    ch = text[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Drop keyword candidates that do not match c at position pos.
    function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] cand,
                                                      input logic [2:0] pos,
                                                      input logic [7:0] c);
        logic [KW_COUNT-1:0] res;
        res = cand;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (pos >= kw_len(2'(k)) || kw_char(2'(k), pos) != c) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

/* hw/rtl/micro_token_scanner_unit.sv */
// Character-serial token scanner with a four-entry result queue.
//
// One ASCII character (or an end-of-input mark) enters per cycle while o_ready
// is high; each item yields zero, one or two results, and the last result of
// an item carries o_last_of_item. The scan state is updated in the accepting
// cycle and the results land in a four-entry queue, so a result appears at the
// earliest in the cycle after its item. The queue drains one result per cycle
// while i_ready is high; o_ready drops while it holds three or more results,
// so a slow sink stalls the input. Items that give at most one result run at
// one item per cycle while the sink keeps up; items that give two results are
// held to the output rate of one result per cycle and so cannot enter on every cycle.
// Identifiers are matched against BEGIN, READ, WRITE and END; integers, reals
// with optional exponent, punctuation, := and newline are recognized; spaces
// and tabs are skipped; any other character gives an ERROR result.
module micro_token_scanner_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_token_code,
    output logic [7:0] o_error_byte,
    output logic       o_last_of_item
);
    import mts_pkg::*;

    localparam int QDEPTH = 4;

    t_mode               r_mode, n_mode;
    logic [KW_COUNT-1:0] r_cand, n_cand;
    logic [2:0]          r_len, n_len;

    t_tok       r_q_code [QDEPTH];
    logic [7:0] r_q_err  [QDEPTH];
    logic       r_q_last [QDEPTH];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;

    logic       accept, pop;
    logic       letter, digit, absorb, assign_hit;
    logic       flush_v, idle_v;
    t_tok       flush_code, idle_code;
    logic [7:0] flush_err, idle_err;
    logic       a_v, b_v;
    t_tok       a_code, b_code, res0_code, res1_code;
    logic [7:0] a_err, b_err, res0_err, res1_err;
    logic [1:0] res_n;

    assign o_ready = r_cnt <= 3'd2;
    assign o_valid = r_cnt != 3'd0;
    assign accept  = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    assign o_token_code   = r_q_code[r_rd];
    assign o_error_byte   = r_q_err[r_rd];
    assign o_last_of_item = r_q_last[r_rd];

    assign letter     = is_letter(i_in_byte);
    assign digit      = is_digit(i_in_byte);
    assign assign_hit = (r_mode == MODE_COLON) && (i_in_byte == CH_EQUAL);

    // Characters that extend the pending token.
    always_comb begin
        case (r_mode)
            MODE_IDENT:    absorb = letter || digit || i_in_byte == CH_UNDER;
            MODE_INT:      absorb = digit || i_in_byte == CH_POINT;
            MODE_FRAC:     absorb = digit || i_in_byte == CH_EXP;
            MODE_EXP_E:    absorb = digit || i_in_byte == CH_PLUS || i_in_byte == CH_MINUS;
            MODE_EXP_TAIL: absorb = digit;
            default:       absorb = 1'b0;
        endcase
    end

    // Next state of the scanner.
    always_comb begin
        n_mode = r_mode;
        n_cand = r_cand;
        n_len  = r_len;
        if (i_end_of_input) begin
            n_mode = MODE_IDLE;
            n_cand = '0;
            n_len  = '0;
        end else if (absorb) begin
            case (r_mode)
                MODE_IDENT: begin
                    n_cand = kw_filter(r_cand, r_len, i_in_byte);
                    n_len  = (r_len == 3'd7) ? r_len : r_len + 3'd1;
                end
                MODE_INT: begin
                    if (i_in_byte == CH_POINT) n_mode = MODE_FRAC;
                end
                MODE_FRAC: begin
                    if (i_in_byte == CH_EXP) n_mode = MODE_EXP_E;
                end
                MODE_EXP_E: n_mode = MODE_EXP_TAIL;
                default:    n_mode = r_mode;
            endcase
        end else if (assign_hit) begin
            n_mode = MODE_IDLE;
        end else begin
            // Close the pending token and restart on this character.
            n_cand = '0;
            n_len  = '0;
            if (letter) begin
                n_mode = MODE_IDENT;
                n_cand = kw_filter({KW_COUNT{1'b1}}, 3'd0, i_in_byte);
                n_len  = 3'd1;
            end else if (digit) begin
                n_mode = MODE_INT;
            end else if (i_in_byte == CH_COLON) begin
                n_mode = MODE_COLON;
            end else begin
                n_mode = MODE_IDLE;
            end
        end
    end

    // Results of the item: pending token first, then the new one.
    always_comb begin
        flush_v    = 1'b1;
        flush_code = TK_IDENT;
        flush_err  = 8'h00;
        case (r_mode)
            MODE_IDENT: begin
                for (int k = 0; k < KW_COUNT; k++) begin
                    if (r_cand[k] && r_len == kw_len(2'(k))) flush_code = t_tok'(5'(k));
                end
            end
            MODE_INT:      flush_code = TK_INT;
            MODE_FRAC,
            MODE_EXP_E,
            MODE_EXP_TAIL: flush_code = TK_REAL;
            MODE_COLON: begin
                flush_code = TK_ERROR;
                flush_err  = CH_COLON;
            end
            default:       flush_v = 1'b0;
        endcase

        idle_v   = 1'b1;
        idle_err = 8'h00;
        case (i_in_byte)
            CH_LF:     idle_code = TK_NEWLINE;
            CH_LPAREN: idle_code = TK_LPAREN;
            CH_RPAREN: idle_code = TK_RPAREN;
            CH_SEMI:   idle_code = TK_SEMI;
            CH_COMMA:  idle_code = TK_COMMA;
            CH_PLUS:   idle_code = TK_PLUS;
            CH_MINUS:  idle_code = TK_MINUS;
            default: begin
                idle_code = TK_ERROR;
                idle_err  = i_in_byte;
            end
        endcase
        if (letter || digit || i_in_byte == CH_SPACE || i_in_byte == CH_TAB
            || i_in_byte == CH_COLON) begin
            idle_v = 1'b0;
        end

        a_v    = 1'b0;
        a_code = TK_EOF;
        a_err  = 8'h00;
        b_v    = 1'b0;
        b_code = TK_EOF;
        b_err  = 8'h00;
        if (i_end_of_input) begin
            a_v    = flush_v;
            a_code = flush_code;
            a_err  = flush_err;
            b_v    = 1'b1;
        end else if (absorb) begin
            a_v = 1'b0;
        end else if (assign_hit) begin
            b_v    = 1'b1;
            b_code = TK_ASSIGN;
        end else begin
            a_v    = flush_v;
            a_code = flush_code;
            a_err  = flush_err;
            b_v    = idle_v;
            b_code = idle_code;
            b_err  = idle_err;
        end

        // Pack valid results toward slot zero.
        res1_code = b_code;
        res1_err  = b_err;
        if (a_v) begin
            res0_code = a_code;
            res0_err  = a_err;
            res_n     = b_v ? 2'd2 : 2'd1;
        end else begin
            res0_code = b_code;
            res0_err  = b_err;
            res_n     = b_v ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_cand <= '0;
            r_len  <= '0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
        end else begin
            if (accept) begin
                r_mode <= n_mode;
                r_cand <= n_cand;
                r_len  <= n_len;
                r_wr   <= r_wr + res_n;
            end
            if (pop) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + (accept ? {1'b0, res_n} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    // Queue payload: write up to two results per accepted item.
    always_ff @(posedge i_clk) begin
        if (accept && res_n != 2'd0) begin
            r_q_code[r_wr] <= res0_code;
            r_q_err[r_wr]  <= res0_err;
            r_q_last[r_wr] <= (res_n == 2'd1);
        end
        if (accept && res_n == 2'd2) begin
            r_q_code[r_wr + 2'd1] <= res1_code;
            r_q_err[r_wr + 2'd1]  <= res1_err;
            r_q_last[r_wr + 2'd1] <= 1'b1;
        end
    end

endmodule

/* hw/rtl/mts_checker.sv */
// Port-level checks for the micro token scanner and their bind.
module mts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [4:0] o_token_code,
    input logic [7:0] o_error_byte,
    input logic       o_last_of_item
);
    import mts_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_code)
            && $stable(o_error_byte) && $stable(o_last_of_item))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_code != 5'(TK_ERROR) |-> o_error_byte == 8'h00)
        else $error("error byte set on a non-error token");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_code == 5'(TK_EOF) |-> o_last_of_item)
        else $error("EOF not last of its item");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_token_code <= 5'(TK_EOF))
        else $error("token code out of range");

    // A result from an empty queue needs an item accepted in the cycle before.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !(i_valid && o_ready) |=> !o_valid)
        else $error("result without an item");

endmodule

bind micro_token_scanner_unit mts_checker u_mts_checker (.*);

/* bench/tb_micro_token_scanner_unit.sv */
// Self-checking testbench for the micro token scanner: directed and random character streams.
module tb_micro_token_scanner_unit;
    import mts_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        t_tok       code;
        logic [7:0] err;
        logic       last;
    } t_tok_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_end_of_input;
    logic       o_valid;
    logic       i_ready;
    logic [4:0] o_token_code;
    logic [7:0] o_error_byte;
    logic       o_last_of_item;

    micro_token_scanner_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_code   (o_token_code),
        .o_error_byte   (o_error_byte),
        .o_last_of_item (o_last_of_item)
    );

    // Scanner state as the predictor sees it
    t_mode       mode_q;
    logic [3:0]  cand_q;
    logic [2:0]  len_q;
    string       kw_word[4] = '{"BEGIN", "READ", "WRITE", "END"};

    t_tok_result step_tokens[$];
    t_tok_result tok_expect_q[$];
    t_tok_result head_tok;

    int error_count;
    int cycle_count;
    int items_sent;
    int send_gap_max;
    int recv_gap_max;
    int sink_hold_cycles;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d tokens outstanding", tok_expect_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        end
        error_count++;
    endtask

    function automatic logic alpha_ch(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic num_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit_token(input t_tok code, input logic [7:0] err);
        step_tokens.push_back('{code: code, err: err, last: 1'b0});
    endfunction

    // Narrow the keyword mask with the character at the current position.
    function automatic void cand_update(input logic [7:0] c);
        for (int k = 0; k < 4; k++) begin
            if (len_q >= kw_word[k].len() || kw_word[k][len_q] != c) begin
                cand_q[k] = 1'b0;
            end
        end
        if (len_q != 3'd7) begin
            len_q = len_q + 3'd1;
        end
    endfunction

    function automatic void close_token();
        t_tok code;
        code = TK_IDENT;
        case (mode_q)
            MODE_IDENT: begin
                for (int k = 0; k < 4; k++) begin
                    if (cand_q[k] && len_q == kw_word[k].len()) begin
                        code = t_tok'(k);
                    end
                end
                emit_token(code, 8'h00);
            end
            MODE_INT:                           emit_token(TK_INT, 8'h00);
            MODE_FRAC, MODE_EXP_E, MODE_EXP_TAIL: emit_token(TK_REAL, 8'h00);
            MODE_COLON:                         emit_token(TK_ERROR, CH_COLON);
            default: ;
        endcase
        mode_q = MODE_IDLE;
        cand_q = 4'h0;
        len_q  = 3'd0;
    endfunction

    function automatic void start_token(input logic [7:0] c);
        if (alpha_ch(c)) begin
            mode_q = MODE_IDENT;
            cand_q = 4'hF;
            len_q  = 3'd0;
            cand_update(c);
        end else if (num_ch(c)) begin
            mode_q = MODE_INT;
        end else begin
            case (c)
                CH_SPACE, CH_TAB: ;
                CH_COLON:  mode_q = MODE_COLON;
                CH_LF:     emit_token(TK_NEWLINE, 8'h00);
                CH_LPAREN: emit_token(TK_LPAREN, 8'h00);
                CH_RPAREN: emit_token(TK_RPAREN, 8'h00);
                CH_SEMI:   emit_token(TK_SEMI, 8'h00);
                CH_COMMA:  emit_token(TK_COMMA, 8'h00);
                CH_PLUS:   emit_token(TK_PLUS, 8'h00);
                CH_MINUS:  emit_token(TK_MINUS, 8'h00);
                default:   emit_token(TK_ERROR, c);
            endcase
        end
    endfunction

    // Advance the predicted scanner by one item and queue the tokens it yields.
    function automatic void scan_predict(input logic [7:0] c, input logic eoi);
        logic absorbed;
        absorbed = 1'b0;
        step_tokens.delete();
        if (eoi) begin
            close_token();
            emit_token(TK_EOF, 8'h00);
        end else begin
            case (mode_q)
                MODE_IDENT: begin
                    if (alpha_ch(c) || num_ch(c) || c == CH_UNDER) begin
                        cand_update(c);
                        absorbed = 1'b1;
                    end
                end
                MODE_INT: begin
                    if (num_ch(c)) begin
                        absorbed = 1'b1;
                    end else if (c == CH_POINT) begin
                        mode_q   = MODE_FRAC;
                        absorbed = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (num_ch(c)) begin
                        absorbed = 1'b1;
                    end else if (c == CH_EXP) begin
                        mode_q   = MODE_EXP_E;
                        absorbed = 1'b1;
                    end
                end
                MODE_EXP_E: begin
                    if (num_ch(c) || c == CH_PLUS || c == CH_MINUS) begin
                        mode_q   = MODE_EXP_TAIL;
                        absorbed = 1'b1;
                    end
                end
                MODE_EXP_TAIL: begin
                    if (num_ch(c)) begin
                        absorbed = 1'b1;
                    end
                end
                MODE_COLON: begin
                    if (c == CH_EQUAL) begin
                        mode_q = MODE_IDLE;
                        emit_token(TK_ASSIGN, 8'h00);
                        absorbed = 1'b1;
                    end
                end
                default: mode_q = MODE_IDLE;
            endcase
            if (!absorbed) begin
                close_token();
                start_token(c);
            end
        end
        if (step_tokens.size() != 0) begin
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        end
        foreach (step_tokens[i]) begin
            tok_expect_q.push_back(step_tokens[i]);
        end
    endfunction

    // Offer one item, hold it until accepted, then predict its tokens.
    task automatic send_char(input logic [7:0] c, input logic eoi);
        int gap;
        gap = $urandom_range(send_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_in_byte      <= c;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        scan_predict(c, eoi);
        items_sent++;
    endtask

    task automatic send_end();
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1) == 0) begin
            return "A" + 8'($urandom_range(25));
        end
        return "a" + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(2))
            0:       return rand_letter();
            1:       return rand_digit();
            default: return CH_UNDER;
        endcase
    endfunction

    // Mostly well-formed lexemes with random content, some noise and broken pieces.
    task automatic send_random_lexeme();
        logic [7:0] lex[$];
        int         pick;
        int         k;
        pick = $urandom_range(99);
        if (pick < 15) begin
            k = $urandom_range(3);
            for (int i = 0; i < kw_word[k].len(); i++) begin
                lex.push_back(kw_word[k][i]);
            end
            case ($urandom_range(3))
                0: lex.push_back(rand_word_char());
                1: void'(lex.pop_back());
                2: lex[0] = lex[0] + ("a" - "A");
                default: ;
            endcase
        end else if (pick < 35) begin
            lex.push_back(rand_letter());
            repeat ($urandom_range(9)) lex.push_back(rand_word_char());
        end else if (pick < 50) begin
            repeat ($urandom_range(4, 1)) lex.push_back(rand_digit());
        end else if (pick < 65) begin
            repeat ($urandom_range(3, 1)) lex.push_back(rand_digit());
            lex.push_back(CH_POINT);
            repeat ($urandom_range(3)) lex.push_back(rand_digit());
            if ($urandom_range(1) == 0) begin
                lex.push_back(CH_EXP);
                case ($urandom_range(2))
                    1: lex.push_back(CH_PLUS);
                    2: lex.push_back(CH_MINUS);
                    default: ;
                endcase
                repeat ($urandom_range(2)) lex.push_back(rand_digit());
            end
        end else if (pick < 80) begin
            case ($urandom_range(7))
                0: lex.push_back(CH_LPAREN);
                1: lex.push_back(CH_RPAREN);
                2: lex.push_back(CH_SEMI);
                3: lex.push_back(CH_COMMA);
                4: lex.push_back(CH_PLUS);
                5: lex.push_back(CH_MINUS);
                6: lex.push_back(CH_LF);
                default: begin
                    lex.push_back(CH_COLON);
                    lex.push_back(CH_EQUAL);
                end
            endcase
        end else if (pick < 87) begin
            lex.push_back(($urandom_range(1) == 0) ? CH_SPACE : CH_TAB);
        end else if (pick < 95) begin
            lex.push_back(8'($urandom_range(255)));
        end else begin
            lex.push_back(CH_COLON);
        end
        foreach (lex[i]) begin
            send_char(lex[i], 1'b0);
        end
        if ($urandom_range(2) == 0) begin
            send_char(CH_SPACE, 1'b0);
        end
        if ($urandom_range(39) == 0) begin
            send_end();
        end
    endtask

    task automatic test_keywords();
        send_text("READ,WRITE;END");
        send_end();
    endtask

    // Real with dangling signed exponent, integer before 'e', real without fraction.
    task automatic test_numbers();
        send_text("12.e+(3e)7.-");
        send_end();
    endtask

    // Lone colon, assign, blanks, unknown bytes at both extremes, colon at end of input.
    task automatic test_separators_and_errors();
        send_text("BEGIN:x:=+\t");
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h0D, 1'b0);
        send_text("\n:");
        send_end();
    endtask

    task automatic test_random_source(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) send_random_lexeme();
    endtask

    task automatic test_streaming(input int count);
        send_gap_max = 0;
        recv_gap_max = 0;
        test_random_source(count);
        send_gap_max = 4;
        recv_gap_max = 4;
    endtask

    // Stall the sink while two-token items keep coming, so the result queue fills.
    task automatic test_backpressure();
        send_gap_max     = 0;
        recv_gap_max     = 0;
        sink_hold_cycles = 80;
        repeat (60) begin
            send_text("x+");
            send_text("1)");
        end
        send_gap_max = 4;
        recv_gap_max = 4;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (tok_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected token code %0d", o_token_code));
            end else begin
                head_tok = tok_expect_q.pop_front();
                if (o_token_code !== head_tok.code) begin
                    report_mismatch($sformatf("token_code %0d, want %0d",
                                              o_token_code, head_tok.code));
                end
                if (o_error_byte !== head_tok.err) begin
                    report_mismatch($sformatf("error_byte %02h, want %02h",
                                              o_error_byte, head_tok.err));
                end
                if (o_last_of_item !== head_tok.last) begin
                    report_mismatch($sformatf("last_of_item %0b, want %0b",
                                              o_last_of_item, head_tok.last));
                end
            end
        end
    end

    // Sink: random hold-off per result, plus one long stall on request.
    initial begin : result_sink
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
            end
            gap = $urandom_range(recv_gap_max);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_in_byte        = 8'h00;
        i_end_of_input   = 1'b0;
        error_count      = 0;
        cycle_count      = 0;
        items_sent       = 0;
        send_gap_max     = 4;
        recv_gap_max     = 4;
        sink_hold_cycles = 0;
        mode_q           = MODE_IDLE;
        cand_q           = 4'h0;
        len_q            = 3'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_keywords();
        test_numbers();
        test_separators_and_errors();
        test_random_source(900);
        test_streaming(250);
        test_backpressure();
        test_random_source(250);

        i_valid <= 1'b0;
        while (tok_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mts_pkg.sv
hw/rtl/micro_token_scanner_unit.sv
hw/rtl/mts_checker.sv
bench/tb_micro_token_scanner_unit.sv
